// ===== design/cbs_pkg.sv =====
// Shared constants and types for the cubic Bezier split unit.
package cbs_pkg;

  localparam int NUM_REGS   = 8;
  localparam int NUM_POINTS = 7;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_STAGES = 10;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_CTRL1_X,
    REG_CTRL1_Y,
    REG_CTRL2_X,
    REG_CTRL2_Y,
    REG_END_X,
    REG_END_Y
  } reg_idx_t;

  // Output order: first half P0, AB, ABC, split point, then BCD, CD, P3.
  typedef enum logic [2:0] {
    PT_START,
    PT_AB,
    PT_ABC,
    PT_SPLIT,
    PT_BCD,
    PT_CD,
    PT_END
  } pt_idx_t;

endpackage

// ===== design/cubic_bezier_split_at_t_unit.sv =====
// Cubic Bezier split at t: de Casteljau pipeline with a seven-word output sequencer.
//
// Splits the cubic curve held in the eight control-point registers at each
// incoming t (unsigned, 2^T_FRAC_BITS = 1.0, larger values clamp to 1.0) and
// sends seven words: P0, AB, ABC, split point, BCD, CD, P3, the last flagged.
// The three interpolation levels run in a ten-stage pipeline (clamp, then
// difference, multiply, add per level), and the first word of an item is sent
// once the item has left the last stage. The single result channel moves one
// word per cycle while out_stall is low; the pipeline keeps accepting while
// earlier results drain and holds up to ten items in its stages plus the one
// being sent. The user must write the control-point registers over the APB
// port only while the unit idles; the unit itself does not enforce this.
module cubic_bezier_split_at_t_unit
  import cbs_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration port
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0] cfg_paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] cfg_pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] cfg_prdata,
  output logic                                   cfg_pready,
  // t input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [T_FRAC_BITS:0]                   in_split_t,
  // point output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [2:0]                             out_point_index,
  output logic signed [COORD_WIDTH-1:0]          out_point_x,
  output logic signed [COORD_WIDTH-1:0]          out_point_y,
  output logic                                   out_last_point
);

  localparam int CW     = COORD_WIDTH;
  localparam int TF     = T_FRAC_BITS;
  localparam int TW     = TF + 1;
  localparam int DW     = (CW > 32) ? 64 : 32;
  localparam int AW     = (CW > 32) ? 6 : 5;
  localparam int DIFF_W = CW + 1;
  localparam int PROD_W = CW + TW + 2;
  localparam logic [TW-1:0] T_ONE = {1'b1, {TF{1'b0}}};

  typedef logic signed [CW-1:0]     coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [TW-1:0]            tval_t;

  // ---------------- configuration registers ----------------
  coord_t                cfg_r [NUM_REGS];
  logic [REG_IDX_W-1:0]  cfg_idx;
  logic signed [DW-1:0]  cfg_rd;

  assign cfg_idx    = cfg_paddr[AW-1:AW-REG_IDX_W];
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_rd     = DW'(cfg_r[cfg_idx]);
    cfg_prdata = cfg_rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      cfg_r[cfg_idx] <= cfg_pwdata[CW-1:0];
    end
  end

  // ctl[c][i]: coordinate c (0 = x, 1 = y) of control point i
  coord_t ctl [2][4];

  always_comb begin
    ctl[0][0] = cfg_r[REG_START_X];
    ctl[1][0] = cfg_r[REG_START_Y];
    ctl[0][1] = cfg_r[REG_CTRL1_X];
    ctl[1][1] = cfg_r[REG_CTRL1_Y];
    ctl[0][2] = cfg_r[REG_CTRL2_X];
    ctl[1][2] = cfg_r[REG_CTRL2_Y];
    ctl[0][3] = cfg_r[REG_END_X];
    ctl[1][3] = cfg_r[REG_END_Y];
  end

  // ---------------- pipeline flow control ----------------
  logic [NUM_STAGES:1] vld_r;
  logic [NUM_STAGES:1] rdy;
  logic                seq_take;

  always_comb begin
    rdy[NUM_STAGES] = !vld_r[NUM_STAGES] || seq_take;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------- datapath ----------------
  tval_t  s1_t_r, s2_t_r, s3_t_r, s4_t_r, s5_t_r, s6_t_r, s7_t_r, s8_t_r;
  diff_t  s2_d_r  [2][3];
  prod_t  s3_p_r  [2][3];
  coord_t s4_l1_r [2][3];
  coord_t s5_l1_r [2][3];
  diff_t  s5_d_r  [2][2];
  coord_t s6_l1_r [2][3];
  prod_t  s6_p_r  [2][2];
  coord_t s7_ab_r [2], s7_cd_r [2];
  coord_t s7_l2_r [2][2];
  coord_t s8_ab_r [2], s8_cd_r [2];
  coord_t s8_l2_r [2][2];
  diff_t  s8_d_r  [2];
  coord_t s9_ab_r [2], s9_cd_r [2];
  coord_t s9_l2_r [2][2];
  prod_t  s9_p_r  [2];
  coord_t s10_ab_r [2], s10_cd_r [2];
  coord_t s10_l2_r [2][2];
  coord_t s10_mid_r [2];

  tval_t t_sat;
  assign t_sat = (in_split_t > T_ONE) ? T_ONE : in_split_t;

  always_ff @(posedge clk) begin
    // stage 1: clamp t
    if (rdy[1]) begin
      s1_t_r <= t_sat;
    end
    // stage 2: level-one differences
    if (rdy[2]) begin
      s2_t_r <= s1_t_r;
      for (int c = 0; c < 2; c++) begin
        for (int j = 0; j < 3; j++) begin
          s2_d_r[c][j] <= {ctl[c][j+1][CW-1], ctl[c][j+1]} - {ctl[c][j][CW-1], ctl[c][j]};
        end
      end
    end
    // stage 3: level-one products
    if (rdy[3]) begin
      s3_t_r <= s2_t_r;
      for (int c = 0; c < 2; c++) begin
        for (int j = 0; j < 3; j++) begin
          s3_p_r[c][j] <= PROD_W'(s2_d_r[c][j]) * PROD_W'($signed({1'b0, s2_t_r}));
        end
      end
    end
    // stage 4: AB, BC, CD (floor of product by dropping fraction bits)
    if (rdy[4]) begin
      s4_t_r <= s3_t_r;
      for (int c = 0; c < 2; c++) begin
        for (int j = 0; j < 3; j++) begin
          s4_l1_r[c][j] <= ctl[c][j] + s3_p_r[c][j][TF +: CW];
        end
      end
    end
    // stage 5: level-two differences
    if (rdy[5]) begin
      s5_t_r  <= s4_t_r;
      s5_l1_r <= s4_l1_r;
      for (int c = 0; c < 2; c++) begin
        for (int j = 0; j < 2; j++) begin
          s5_d_r[c][j] <= {s4_l1_r[c][j+1][CW-1], s4_l1_r[c][j+1]}
                        - {s4_l1_r[c][j][CW-1], s4_l1_r[c][j]};
        end
      end
    end
    // stage 6: level-two products
    if (rdy[6]) begin
      s6_t_r  <= s5_t_r;
      s6_l1_r <= s5_l1_r;
      for (int c = 0; c < 2; c++) begin
        for (int j = 0; j < 2; j++) begin
          s6_p_r[c][j] <= PROD_W'(s5_d_r[c][j]) * PROD_W'($signed({1'b0, s5_t_r}));
        end
      end
    end
    // stage 7: ABC, BCD
    if (rdy[7]) begin
      s7_t_r <= s6_t_r;
      for (int c = 0; c < 2; c++) begin
        s7_ab_r[c] <= s6_l1_r[c][0];
        s7_cd_r[c] <= s6_l1_r[c][2];
        for (int j = 0; j < 2; j++) begin
          s7_l2_r[c][j] <= s6_l1_r[c][j] + s6_p_r[c][j][TF +: CW];
        end
      end
    end
    // stage 8: level-three difference
    if (rdy[8]) begin
      s8_t_r  <= s7_t_r;
      s8_ab_r <= s7_ab_r;
      s8_cd_r <= s7_cd_r;
      s8_l2_r <= s7_l2_r;
      for (int c = 0; c < 2; c++) begin
        s8_d_r[c] <= {s7_l2_r[c][1][CW-1], s7_l2_r[c][1]}
                   - {s7_l2_r[c][0][CW-1], s7_l2_r[c][0]};
      end
    end
    // stage 9: level-three product
    if (rdy[9]) begin
      s9_ab_r <= s8_ab_r;
      s9_cd_r <= s8_cd_r;
      s9_l2_r <= s8_l2_r;
      for (int c = 0; c < 2; c++) begin
        s9_p_r[c] <= PROD_W'(s8_d_r[c]) * PROD_W'($signed({1'b0, s8_t_r}));
      end
    end
    // stage 10: split point
    if (rdy[10]) begin
      s10_ab_r <= s9_ab_r;
      s10_cd_r <= s9_cd_r;
      s10_l2_r <= s9_l2_r;
      for (int c = 0; c < 2; c++) begin
        s10_mid_r[c] <= s9_l2_r[c][0] + s9_p_r[c][TF +: CW];
      end
    end
  end

  // ---------------- output sequencer ----------------
  logic    busy_r;
  pt_idx_t idx_r;
  coord_t  hold_ab_r [2], hold_abc_r [2], hold_mid_r [2], hold_bcd_r [2], hold_cd_r [2];
  logic    out_fire;
  logic    seq_load;

  assign out_fire = busy_r && !out_stall;
  assign seq_take = !busy_r || (out_fire && idx_r == PT_END);
  assign seq_load = vld_r[NUM_STAGES] && seq_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= PT_START;
    end else if (seq_load) begin
      busy_r <= 1'b1;
      idx_r  <= PT_START;
    end else if (out_fire) begin
      if (idx_r == PT_END) begin
        busy_r <= 1'b0;
        idx_r  <= PT_START;
      end else begin
        idx_r <= pt_idx_t'(idx_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_load) begin
      for (int c = 0; c < 2; c++) begin
        hold_ab_r[c]  <= s10_ab_r[c];
        hold_abc_r[c] <= s10_l2_r[c][0];
        hold_mid_r[c] <= s10_mid_r[c];
        hold_bcd_r[c] <= s10_l2_r[c][1];
        hold_cd_r[c]  <= s10_cd_r[c];
      end
    end
  end

  // end points come straight from registers; only the user holds them while busy
  coord_t pt_sel [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      case (idx_r)
        PT_START: pt_sel[c] = ctl[c][0];
        PT_AB:    pt_sel[c] = hold_ab_r[c];
        PT_ABC:   pt_sel[c] = hold_abc_r[c];
        PT_SPLIT: pt_sel[c] = hold_mid_r[c];
        PT_BCD:   pt_sel[c] = hold_bcd_r[c];
        PT_CD:    pt_sel[c] = hold_cd_r[c];
        PT_END:   pt_sel[c] = ctl[c][3];
        default:  pt_sel[c] = ctl[c][0];
      endcase
    end
  end

  assign out_valid       = busy_r;
  assign out_point_index = idx_r;
  assign out_point_x     = pt_sel[0];
  assign out_point_y     = pt_sel[1];
  assign out_last_point  = (idx_r == PT_END);

endmodule
